// ===== hw/rtl/nrt_pkg.sv =====
// Package for the neighbor route table update unit.
// Holds field types, status and register codes and reset values; no dependencies.

package nrt_pkg;

	localparam int NRT_TABLE_ENTRIES = 16;

	typedef logic [7:0] id_t;
	typedef logic [2:0] status_t;
	typedef logic [3:0] slot_t;
	typedef logic [1:0] cfg_idx_t;

	localparam status_t ST_IGNORED  = 3'd0;
	localparam status_t ST_UPDATED  = 3'd1;
	localparam status_t ST_KEPT     = 3'd2;
	localparam status_t ST_INSERTED = 3'd3;
	localparam status_t ST_FULL     = 3'd4;

	localparam cfg_idx_t CFG_OWN_ID       = 2'd0;
	localparam cfg_idx_t CFG_EMPTY_MARKER = 2'd1;
	localparam cfg_idx_t CFG_MAX_HOPS     = 2'd2;

	localparam id_t OWN_ID_RST       = 8'd255;
	localparam id_t EMPTY_MARKER_RST = 8'd255;
	localparam id_t MAX_HOPS_RST     = 8'd1;

	localparam id_t ENTRY_NODE_RST = 8'd255;
	localparam id_t ENTRY_NH_RST   = 8'd0;
	localparam id_t ENTRY_HOPS_RST = 8'd255;

	typedef struct packed {
		id_t node;
		id_t next_hop;
		id_t hops;
	} entry_t;

	typedef struct packed {
		id_t own_id;
		id_t empty_marker;
		id_t max_hops;
	} cfg_t;

	typedef struct packed {
		status_t status;
		slot_t   slot;
		id_t     next_hop;
		id_t     hops;
	} result_t;

endpackage

// ===== hw/rtl/nrt_if.sv =====
// Channel interfaces of the neighbor route table update unit.
// Depends on nrt_pkg for the field types.

interface nrt_in_if;
	logic          valid;
	logic          ready;
	nrt_pkg::id_t  node_id;
	nrt_pkg::id_t  next_hop;
	nrt_pkg::id_t  hop_count;

	modport source (output valid, node_id, next_hop, hop_count, input ready);
	modport sink (input valid, node_id, next_hop, hop_count, output ready);
endinterface

interface nrt_out_if;
	logic             valid;
	logic             ready;
	nrt_pkg::status_t status;
	nrt_pkg::slot_t   slot;
	nrt_pkg::id_t     stored_next_hop;
	nrt_pkg::id_t     stored_hops;

	modport source (output valid, status, slot, stored_next_hop, stored_hops, input ready);
	modport sink (input valid, status, slot, stored_next_hop, stored_hops, output ready);
endinterface

interface nrt_cfg_if;
	logic              valid;
	logic              ready;
	nrt_pkg::cfg_idx_t index;
	nrt_pkg::id_t      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/nrt_table.sv =====
// Neighbor table storage: one write and one registered read port, plus valid flops.
// Depends on nrt_pkg; an entry that was never written reads as its reset value.

module nrt_table #(
	parameter int TABLE_ENTRIES = nrt_pkg::NRT_TABLE_ENTRIES,
	parameter int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [IW-1:0]   rd_idx,
	input  logic            wr_en,
	input  logic [IW-1:0]   wr_idx,
	input  nrt_pkg::entry_t wr_data,
	output nrt_pkg::entry_t rd_data
);
	import nrt_pkg::*;

	entry_t                   mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] vld_q;
	entry_t                   rd_data_q;
	logic                     rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_idx];
			end
		end
	end

	always_comb begin
		if (rd_vld_q) begin
			rd_data = rd_data_q;
		end else begin
			rd_data.node     = ENTRY_NODE_RST;
			rd_data.next_hop = ENTRY_NH_RST;
			rd_data.hops     = ENTRY_HOPS_RST;
		end
	end

endmodule

// ===== hw/rtl/nrt_seq.sv =====
// Sequencer: walks the table one entry per cycle through a shared compare unit,
// decides ignore, update, keep, insert or full, and holds the result register. Uses nrt_pkg.

module nrt_seq #(
	parameter int TABLE_ENTRIES = nrt_pkg::NRT_TABLE_ENTRIES,
	parameter int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  nrt_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  nrt_pkg::entry_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output nrt_pkg::result_t out_data,
	output logic             rd_en,
	output logic [IW-1:0]    rd_idx,
	input  nrt_pkg::entry_t  rd_data,
	output logic             wr_en,
	output logic [IW-1:0]    wr_idx,
	output nrt_pkg::entry_t  wr_data
);
	import nrt_pkg::*;

	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_ENTRIES);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]    state_q;
	entry_t        req_q;
	logic [CW-1:0] cnt_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          have_empty_q;
	logic [IW-1:0] empty_idx_q;
	result_t       pend_q;
	result_t       res_q;
	logic          out_vld_q;

	logic ignore;
	logic match;
	logic take_new;
	logic empty_hit;
	logic scan_end;
	logic out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;
	assign out_data  = res_q;
	assign out_free  = !out_vld_q || out_ready;

	always_comb begin
		ignore    = (in_data.hops > cfg.max_hops) || (in_data.node == cfg.own_id) ||
		            (in_data.node == cfg.empty_marker);
		match     = vld_s1 && (rd_data.node == req_q.node);
		take_new  = (req_q.hops <= rd_data.hops) || (rd_data.next_hop == req_q.next_hop);
		empty_hit = vld_s1 && (rd_data.node == cfg.empty_marker);
		scan_end  = !vld_s1 && (cnt_q == LAST_CNT);

		rd_en   = (state_q == S_SCAN) && (cnt_q < LAST_CNT) && !match;
		rd_idx  = cnt_q[IW-1:0];
		wr_en   = (state_q == S_SCAN) &&
		          ((match && take_new) || (scan_end && have_empty_q));
		wr_idx  = match ? idx_s1 : empty_idx_q;
		wr_data = req_q;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_data;
		end
		if (rd_en) begin
			idx_s1 <= cnt_q[IW-1:0];
		end
		if (state_q == S_SCAN && empty_hit && !have_empty_q) begin
			empty_idx_q <= idx_s1;
		end
		if (state_q == S_IDLE && in_valid) begin
			pend_q <= '{status: ST_IGNORED, slot: '0, next_hop: '0, hops: '0};
		end else if (state_q == S_SCAN) begin
			if (match) begin
				pend_q.slot <= slot_t'(idx_s1);
				if (take_new) begin
					pend_q.status   <= ST_UPDATED;
					pend_q.next_hop <= req_q.next_hop;
					pend_q.hops     <= req_q.hops;
				end else begin
					pend_q.status   <= ST_KEPT;
					pend_q.next_hop <= rd_data.next_hop;
					pend_q.hops     <= rd_data.hops;
				end
			end else if (scan_end) begin
				if (have_empty_q) begin
					pend_q <= '{status: ST_INSERTED, slot: slot_t'(empty_idx_q),
					            next_hop: req_q.next_hop, hops: req_q.hops};
				end else begin
					pend_q <= '{status: ST_FULL, slot: '0, next_hop: '0, hops: '0};
				end
			end
		end
		if (state_q == S_FINISH && out_free) begin
			res_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			vld_s1       <= 1'b0;
			have_empty_q <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (state_q == S_FINISH && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cnt_q        <= '0;
					vld_s1       <= 1'b0;
					have_empty_q <= 1'b0;
					if (in_valid) begin
						state_q <= ignore ? S_FINISH : S_SCAN;
					end
				end
				S_SCAN: begin
					vld_s1 <= rd_en;
					if (rd_en) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (empty_hit) begin
						have_empty_q <= 1'b1;
					end
					if (match || scan_end) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/neighbor_route_table_update_unit.sv =====
// Top level of the neighbor route table update unit: configuration registers,
// table storage and scan sequencer. Depends on nrt_pkg, nrt_if, nrt_table, nrt_seq.
//
//   channel  direction  carries
//   cfg      in         register index and write data, always ready
//   req      in         node_id, next_hop, hop_count route report
//   rsp      out        status, slot, stored_next_hop, stored_hops
//
// An ignored report reaches rsp without a table scan; any other waits for the scan that
// reads one table entry per cycle through a single registered read port and stops at
// the first match. Reset empties the table at once through per-entry valid flops.
// req is not ready from its transfer until the result is loaded for rsp; a result
// waiting on rsp does not block the next transfer on req, only that report's result.

module neighbor_route_table_update_unit #(
	parameter int TABLE_ENTRIES = nrt_pkg::NRT_TABLE_ENTRIES
) (
	input logic       clk,
	input logic       arst_n,
	nrt_cfg_if.sink   cfg,
	nrt_in_if.sink    req,
	nrt_out_if.source rsp
);
	import nrt_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	cfg_t          cfg_q;
	entry_t        in_data;
	result_t       out_data;
	logic          rd_en;
	logic [IW-1:0] rd_idx;
	entry_t        rd_data;
	logic          wr_en;
	logic [IW-1:0] wr_idx;
	entry_t        wr_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_id       <= OWN_ID_RST;
			cfg_q.empty_marker <= EMPTY_MARKER_RST;
			cfg_q.max_hops     <= MAX_HOPS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_OWN_ID:       cfg_q.own_id       <= cfg.data;
				CFG_EMPTY_MARKER: cfg_q.empty_marker <= cfg.data;
				CFG_MAX_HOPS:     cfg_q.max_hops     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign in_data.node     = req.node_id;
	assign in_data.next_hop = req.next_hop;
	assign in_data.hops     = req.hop_count;

	assign rsp.status          = out_data.status;
	assign rsp.slot            = out_data.slot;
	assign rsp.stored_next_hop = out_data.next_hop;
	assign rsp.stored_hops     = out_data.hops;

	nrt_seq #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.IW            (IW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_data   (in_data),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (out_data),
		.rd_en     (rd_en),
		.rd_idx    (rd_idx),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_idx    (wr_idx),
		.wr_data   (wr_data)
	);

	nrt_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.IW            (IW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_idx  (rd_idx),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for neighbor_route_table_update_unit: directed route reports,
// then randomized phases under changing register settings, checked against a table predictor.
// Depends on nrt_pkg, the channel interfaces in nrt_if and the unit's RTL.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nrt_pkg::*;

	localparam int MAX_IDLE        = 5;
	localparam int SETTLE_CYCLES   = 4;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int ID_POOL         = 24;
	localparam int REPORT_LIMIT    = 10;
	localparam int CYCLE_LIMIT     = 250000;

	typedef enum logic {ROW_REPORT, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		cfg_idx_t  reg_idx;
		id_t       value;
		entry_t    rep;
		logic      typed;
		result_t   golden;
	} row_t;

	localparam result_t IGNORED_RES = '{ST_IGNORED, 4'd0, 8'd0, 8'd0};
	localparam result_t NO_RES      = '0;
	localparam entry_t  NO_REP      = '0;

	localparam int DIRECTED_ROWS = 26;
	localparam row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd0, 8'd0, 8'd0}, 1'b1,
			'{ST_INSERTED, 4'd0, 8'd0, 8'd0}},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd255, 8'd7, 8'd0}, 1'b1, IGNORED_RES},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd1, 8'd255, 8'd2}, 1'b1, IGNORED_RES},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd0, 8'd9, 8'd1}, 1'b1,
			'{ST_KEPT, 4'd0, 8'd0, 8'd0}},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd0, 8'd0, 8'd1}, 1'b1,
			'{ST_UPDATED, 4'd0, 8'd0, 8'd1}},
		'{ROW_WRITE, CFG_OWN_ID, 8'd0, NO_REP, 1'b0, NO_RES},
		'{ROW_WRITE, CFG_MAX_HOPS, 8'd255, NO_REP, 1'b0, NO_RES},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd0, 8'd3, 8'd0}, 1'b1, IGNORED_RES},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd2, 8'hAA, 8'hFF}, 1'b1,
			'{ST_INSERTED, 4'd1, 8'hAA, 8'hFF}},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd2, 8'h55, 8'hFE}, 1'b1,
			'{ST_UPDATED, 4'd1, 8'h55, 8'hFE}},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd2, 8'h11, 8'hFF}, 1'b1,
			'{ST_KEPT, 4'd1, 8'h55, 8'hFE}},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd2, 8'h55, 8'hFF}, 1'b1,
			'{ST_UPDATED, 4'd1, 8'h55, 8'hFF}},
		'{ROW_WRITE, CFG_EMPTY_MARKER, 8'd7, NO_REP, 1'b0, NO_RES},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd7, 8'd1, 8'd1}, 1'b1, IGNORED_RES},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd100, 8'd1, 8'd1}, 1'b1,
			'{ST_FULL, 4'd0, 8'd0, 8'd0}},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd255, 8'h80, 8'hC8}, 1'b1,
			'{ST_UPDATED, 4'd2, 8'h80, 8'hC8}},
		'{ROW_WRITE, CFG_EMPTY_MARKER, 8'd255, NO_REP, 1'b0, NO_RES},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd100, 8'd1, 8'd1}, 1'b0, NO_RES},
		'{ROW_WRITE, CFG_OWN_ID, 8'd5, NO_REP, 1'b0, NO_RES},
		'{ROW_WRITE, CFG_EMPTY_MARKER, 8'd5, NO_REP, 1'b0, NO_RES},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd5, 8'd1, 8'd1}, 1'b1, IGNORED_RES},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd255, 8'd2, 8'd3}, 1'b0, NO_RES},
		'{ROW_WRITE, CFG_MAX_HOPS, 8'd0, NO_REP, 1'b0, NO_RES},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd9, 8'd1, 8'd0}, 1'b0, NO_RES},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd9, 8'd1, 8'd1}, 1'b1, IGNORED_RES},
		'{ROW_REPORT, CFG_OWN_ID, 8'd0, '{8'd0, 8'd0, 8'd0}, 1'b0, NO_RES}
	};

	logic clk;
	logic arst_n;

	nrt_in_if  req_if ();
	nrt_out_if rsp_if ();
	nrt_cfg_if cfg_if ();

	neighbor_route_table_update_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	cfg_t    regs;
	entry_t  route_tbl [NRT_TABLE_ENTRIES];
	result_t due_results [$];
	int      tally [8];
	int      report_count;
	int      reg_writes;
	int      mismatch_count;
	int      cycle_count;
	bit      in_burst;
	bit      out_burst;

	function automatic result_t apply_report(input entry_t rep);
		result_t res;
		int      hit;
		res = '0;
		hit = -1;
		res.status = ST_IGNORED;
		if (rep.hops > regs.max_hops || rep.node == regs.own_id ||
				rep.node == regs.empty_marker) begin
			return res;
		end
		for (int i = 0; i < NRT_TABLE_ENTRIES; i++) begin
			if (hit < 0 && route_tbl[i].node == rep.node) begin
				hit = i;
			end
		end
		if (hit >= 0) begin
			if (rep.hops <= route_tbl[hit].hops || route_tbl[hit].next_hop == rep.next_hop) begin
				route_tbl[hit].next_hop = rep.next_hop;
				route_tbl[hit].hops = rep.hops;
				res.status = ST_UPDATED;
			end else begin
				res.status = ST_KEPT;
			end
		end else begin
			for (int i = 0; i < NRT_TABLE_ENTRIES; i++) begin
				if (hit < 0 && route_tbl[i].node == regs.empty_marker) begin
					hit = i;
				end
			end
			if (hit < 0) begin
				res.status = ST_FULL;
				return res;
			end
			route_tbl[hit] = rep;
			res.status = ST_INSERTED;
		end
		res.slot = slot_t'(hit);
		res.next_hop = route_tbl[hit].next_hop;
		res.hops = route_tbl[hit].hops;
		return res;
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input id_t data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		case (idx)
			CFG_OWN_ID: regs.own_id = data;
			CFG_EMPTY_MARKER: regs.empty_marker = data;
			CFG_MAX_HOPS: regs.max_hops = data;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic send_report(input entry_t rep, input logic typed, input result_t golden);
		int      gap;
		result_t predicted;
		gap = in_burst ? 0 : $urandom_range(0, MAX_IDLE);
		cfg_if.valid <= 1'b0;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.node_id <= rep.node;
		req_if.next_hop <= rep.next_hop;
		req_if.hop_count <= rep.hops;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		predicted = apply_report(rep);
		tally[predicted.status]++;
		due_results.push_back(typed ? golden : predicted);
		report_count++;
	endtask

	task automatic wait_idle();
		req_if.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : rsp_check
		result_t want;
		result_t got;
		int      stall;
		rsp_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = out_burst ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_if.valid) @(posedge clk);
			got = '{rsp_if.status, rsp_if.slot, rsp_if.stored_next_hop, rsp_if.stored_hops};
			if (due_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("%0t: result with none pending: status %0d slot %0d nh %0d hops %0d",
						$realtime, got.status, got.slot, got.next_hop, got.hops);
				end
			end else begin
				want = due_results.pop_front();
				if (got.status !== want.status || got.slot !== want.slot ||
						got.next_hop !== want.next_hop || got.hops !== want.hops) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display({"%0t: expected status %0d slot %0d nh %0d hops %0d,",
							" got %0d %0d %0d %0d"},
							$realtime, want.status, want.slot, want.next_hop, want.hops,
							got.status, got.slot, got.next_hop, got.hops);
					end
				end
			end
		end
	end

	initial begin : stimulus
		cfg_t   new_regs;
		entry_t rep;
		id_t    base;
		int     pick;
		int     hit;

		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.node_id <= '0;
		req_if.next_hop <= '0;
		req_if.hop_count <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= CFG_OWN_ID;
		cfg_if.data <= '0;
		regs = '{OWN_ID_RST, EMPTY_MARKER_RST, MAX_HOPS_RST};
		foreach (route_tbl[i]) route_tbl[i] = '{ENTRY_NODE_RST, ENTRY_NH_RST, ENTRY_HOPS_RST};
		foreach (tally[i]) tally[i] = 0;
		report_count = 0;
		reg_writes = 0;
		mismatch_count = 0;
		in_burst = 1'b0;
		out_burst = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (DIRECTED[r].kind == ROW_WRITE) begin
				if (r > 0 && DIRECTED[r - 1].kind == ROW_REPORT) wait_idle();
				write_reg(DIRECTED[r].reg_idx, DIRECTED[r].value);
			end else begin
				send_report(DIRECTED[r].rep, DIRECTED[r].typed, DIRECTED[r].golden);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: new_regs = '{8'd0, 8'd255, 8'd255};
				1: new_regs = '{8'd255, 8'd0, 8'd0};
				default: begin
					new_regs.own_id = id_t'($urandom_range(0, 255));
					new_regs.empty_marker = $urandom_range(0, 1) ?
						route_tbl[$urandom_range(0, NRT_TABLE_ENTRIES - 1)].node : EMPTY_MARKER_RST;
					new_regs.max_hops = ($urandom_range(0, 2) == 0) ?
						8'd255 : id_t'($urandom_range(0, 255));
				end
			endcase
			write_reg(CFG_OWN_ID, new_regs.own_id);
			write_reg(CFG_EMPTY_MARKER, new_regs.empty_marker);
			write_reg(CFG_MAX_HOPS, new_regs.max_hops);
			in_burst = (ph % 3 == 1);
			out_burst = (ph % 3 == 2);
			base = id_t'($urandom_range(0, 255));
			repeat (ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) rep.node = base + id_t'($urandom_range(0, ID_POOL - 1));
				else if (pick == 7) rep.node = regs.own_id;
				else if (pick == 8) rep.node = regs.empty_marker;
				else rep.node = id_t'($urandom_range(0, 255));
				hit = -1;
				foreach (route_tbl[i]) begin
					if (hit < 0 && route_tbl[i].node == rep.node) hit = i;
				end
				rep.next_hop = (hit >= 0 && $urandom_range(0, 9) < 4) ?
					route_tbl[hit].next_hop : id_t'($urandom_range(0, 255));
				rep.hops = ($urandom_range(0, 3) != 0) ?
					id_t'($urandom_range(0, regs.max_hops)) : id_t'($urandom_range(0, 255));
				send_report(rep, 1'b0, NO_RES);
				if ($urandom_range(0, 39) == 0) wait_idle();
			end
		end

		req_if.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (NRT_TABLE_ENTRIES + 8) @(posedge clk);
		if (due_results.size() != 0) mismatch_count++;

		$display("Route table: %0d reports (%0d directed rows), %0d register writes, %0d cycles.",
			report_count, DIRECTED_ROWS, reg_writes, cycle_count);
		$display({"Outcomes: %0d ignored, %0d updated, %0d kept, %0d inserted, %0d full;",
			" %0d mismatches."},
			tally[ST_IGNORED], tally[ST_UPDATED], tally[ST_KEPT], tally[ST_INSERTED],
			tally[ST_FULL], mismatch_count);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/nrt_pkg.sv
hw/rtl/nrt_if.sv
hw/rtl/nrt_table.sv
hw/rtl/nrt_seq.sv
hw/rtl/neighbor_route_table_update_unit.sv
tb/tb.sv
